// ===== hdl/hbe_pkg.sv =====
// Shared types and constants for the Huffman byte encoder and packer.
// Used by hbe_front, hbe_table, hbe_pack and the top level; no dependencies.

package hbe_pkg;

	localparam int BYTE_W      = 8;
	localparam int CMD_W       = 2;
	localparam int SYM_W       = 8;
	localparam int IN_WORD_W   = 48;
	localparam int IN_LEN_W    = 6;
	localparam int PAD_W       = 3;
	localparam int OUT_COUNT_W = 32;

	// Slave tdata layout, lowest bit first.
	localparam int SD_SYM_LO   = 0;
	localparam int SD_WORD_LO  = SD_SYM_LO + SYM_W;
	localparam int SD_LEN_LO   = SD_WORD_LO + IN_WORD_W;
	localparam int SD_DATA_LO  = SD_LEN_LO + IN_LEN_W;
	localparam int SD_USED_W   = SD_DATA_LO + BYTE_W;
	localparam int S_TDATA_W   = ((SD_USED_W + 7) / 8) * 8;

	// Master tdata layout, lowest bit first.
	localparam int MD_BYTE_LO  = 0;
	localparam int MD_PAD_LO   = MD_BYTE_LO + BYTE_W;
	localparam int MD_CNT_LO   = MD_PAD_LO + PAD_W;
	localparam int MD_USED_W   = MD_CNT_LO + OUT_COUNT_W;
	localparam int M_TDATA_W   = ((MD_USED_W + 7) / 8) * 8;

	localparam logic [SYM_W-1:0] CH_CR = 8'h0D;
	localparam logic [SYM_W-1:0] CH_LF = 8'h0A;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_SYM,
		OP_FLUSH
	} op_kind_t;

	// One operation from the front end to the code table.
	typedef struct packed {
		op_kind_t               kind;
		logic [SYM_W-1:0]       sym;
		logic [IN_WORD_W-1:0]   word;
		logic [IN_LEN_W-1:0]    len;
	} op_t;

endpackage

// ===== hdl/huffman_byte_encoder_packer.sv =====
// Top level of the Huffman byte encoder and packer.
// Depends on hbe_pkg, hbe_front, hbe_table and hbe_pack.
//
//   channel | signals                        | beat carries
//   slave   | s_tvalid s_tready s_tuser s_tdata | one command: load, encode or flush
//   master  | m_tvalid m_tready m_tuser m_tdata m_tlast | one packed byte or final result
//
// A load or a plain encode becomes one table operation; an encode that releases a held
// CR, or a flush behind a held CR, becomes two. The packer emits one byte per cycle while
// the master side accepts, and a symbol that completes several bytes holds the next one
// back. An encode beat reaches the output through the table's read register, the packer's
// accumulator and the output register; a flush with no held CR skips the accumulator.
// Reset clears the pending CR, the accumulator's bit count, the symbol count and the
// table's written flags; the table contents are kept only as data. A master-side stall
// fills the output register, then the packer and the table stage, and then drops s_tready.

module huffman_byte_encoder_packer #(
	parameter int MAX_CODE_LEN = 48,
	parameter int COUNT_BITS   = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// command
	input  logic [hbe_pkg::CMD_W-1:0]      s_tuser,
	// table_symbol, entry_code_bits, entry_code_length, data_byte, zero fill
	input  logic [hbe_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// byte_present
	output logic                           m_tuser,
	// packed_byte, pad_bits, encoded_symbols, zero fill
	output logic [hbe_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tlast
);

	localparam int LW = $clog2(MAX_CODE_LEN + 1);

	logic                              op_valid;
	logic                              op_ready;
	hbe_pkg::op_t                      op;
	logic                              rd_valid;
	logic                              rd_ready;
	hbe_pkg::op_kind_t                 rd_kind;
	logic [MAX_CODE_LEN-1:0]           rd_word;
	logic [LW-1:0]                     rd_len;
	logic [hbe_pkg::BYTE_W-1:0]        packed_byte;
	logic [hbe_pkg::PAD_W-1:0]         pad_bits;
	logic [hbe_pkg::OUT_COUNT_W-1:0]   encoded_symbols;

	hbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.op_valid (op_valid),
		.op       (op),
		.op_ready (op_ready)
	);

	hbe_table #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.op_ready (op_ready),
		.rd_valid (rd_valid),
		.rd_kind  (rd_kind),
		.rd_word  (rd_word),
		.rd_len   (rd_len),
		.rd_ready (rd_ready)
	);

	hbe_pack #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.COUNT_BITS   (COUNT_BITS)
	) u_pack (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (rd_valid),
		.in_kind         (rd_kind),
		.in_word         (rd_word),
		.in_len          (rd_len),
		.in_ready        (rd_ready),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.packed_byte     (packed_byte),
		.byte_present    (m_tuser),
		.is_last         (m_tlast),
		.pad_bits        (pad_bits),
		.encoded_symbols (encoded_symbols)
	);

	assign m_tdata = hbe_pkg::M_TDATA_W'({encoded_symbols, pad_bits, packed_byte});

endmodule

// ===== hdl/hbe_front.sv =====
// Front end: decodes input beats, folds CR LF into LF and splits items into table ops.
// Depends on hbe_pkg.

module hbe_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [hbe_pkg::CMD_W-1:0]   s_tuser,
	input  logic [hbe_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                        op_valid,
	output hbe_pkg::op_t                op,
	input  logic                        op_ready
);

	logic                        crp_q;
	logic                        second_q;
	hbe_pkg::op_t                second_op_q;

	hbe_pkg::cmd_t               cmd;
	logic [hbe_pkg::SYM_W-1:0]   b;
	hbe_pkg::op_t                first_op;
	hbe_pkg::op_t                next_op;
	logic                        need1;
	logic                        need2;
	logic                        crp_next;
	logic                        accept;

	assign cmd = hbe_pkg::cmd_t'(s_tuser);
	assign b   = s_tdata[hbe_pkg::SD_DATA_LO +: hbe_pkg::BYTE_W];

	always_comb begin
		first_op      = '0;
		first_op.kind = hbe_pkg::OP_SYM;
		first_op.sym  = s_tdata[hbe_pkg::SD_SYM_LO +: hbe_pkg::SYM_W];
		first_op.word = s_tdata[hbe_pkg::SD_WORD_LO +: hbe_pkg::IN_WORD_W];
		first_op.len  = s_tdata[hbe_pkg::SD_LEN_LO +: hbe_pkg::IN_LEN_W];
		next_op       = first_op;
		need1         = 1'b0;
		need2         = 1'b0;
		crp_next      = crp_q;
		unique case (cmd)
			hbe_pkg::CMD_LOAD: begin
				first_op.kind = hbe_pkg::OP_WRITE;
				need1         = 1'b1;
			end
			hbe_pkg::CMD_ENCODE: begin
				if (crp_q) begin
					need1 = 1'b1;
					if (b == hbe_pkg::CH_LF) begin
						first_op.sym = hbe_pkg::CH_LF;
						crp_next     = 1'b0;
					end else begin
						first_op.sym = hbe_pkg::CH_CR;
						if (b == hbe_pkg::CH_CR) begin
							crp_next = 1'b1;
						end else begin
							// The held CR goes out first, then this byte.
							next_op.sym = b;
							need2       = 1'b1;
							crp_next    = 1'b0;
						end
					end
				end else if (b == hbe_pkg::CH_CR) begin
					crp_next = 1'b1;
				end else begin
					first_op.sym = b;
					need1        = 1'b1;
				end
			end
			hbe_pkg::CMD_FLUSH: begin
				need1    = 1'b1;
				crp_next = 1'b0;
				if (crp_q) begin
					first_op.sym = hbe_pkg::CH_CR;
					next_op.kind = hbe_pkg::OP_FLUSH;
					need2        = 1'b1;
				end else begin
					first_op.kind = hbe_pkg::OP_FLUSH;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = !second_q && op_ready;
	assign accept   = s_tvalid && s_tready;
	assign op_valid = second_q || (s_tvalid && need1);
	assign op       = second_q ? second_op_q : first_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crp_q    <= 1'b0;
			second_q <= 1'b0;
		end else if (accept) begin
			crp_q    <= crp_next;
			second_q <= need2;
		end else if (second_q && op_ready) begin
			second_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			second_op_q <= next_op;
		end
	end

endmodule

// ===== hdl/hbe_table.sv =====
// Code table: a 256-entry memory of code words and lengths with a registered read.
// Depends on hbe_pkg; feeds hbe_pack.

module hbe_table #(
	parameter int MAX_CODE_LEN = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           op_valid,
	input  hbe_pkg::op_t                   op,
	output logic                           op_ready,
	output logic                           rd_valid,
	output hbe_pkg::op_kind_t              rd_kind,
	output logic [MAX_CODE_LEN-1:0]        rd_word,
	output logic [$clog2(MAX_CODE_LEN+1)-1:0] rd_len,
	input  logic                           rd_ready
);

	localparam int LW      = $clog2(MAX_CODE_LEN + 1);
	localparam int ENTRY_W = MAX_CODE_LEN + LW;
	localparam int DEPTH   = 1 << hbe_pkg::SYM_W;

	logic [ENTRY_W-1:0]      mem [DEPTH];
	logic [DEPTH-1:0]        written_q;

	logic                    valid_s1;
	hbe_pkg::op_kind_t       kind_s1;
	logic [ENTRY_W-1:0]      entry_s1;
	logic                    written_s1;

	logic                    adv;
	logic [LW-1:0]           len_sat;

	assign op_ready = !valid_s1 || rd_ready;
	assign adv      = op_valid && op_ready;
	assign len_sat  = (int'(op.len) > MAX_CODE_LEN) ? LW'(MAX_CODE_LEN) : LW'(op.len);

	always_ff @(posedge clk) begin
		if (adv && op.kind == hbe_pkg::OP_WRITE) begin
			mem[op.sym] <= {MAX_CODE_LEN'(op.word), len_sat};
		end
		if (adv && op.kind == hbe_pkg::OP_SYM) begin
			entry_s1 <= mem[op.sym];
		end
		if (adv) begin
			kind_s1    <= op.kind;
			written_s1 <= written_q[op.sym];
		end
	end

	// The written flags reset to zero: an entry never loaded reads with length zero, as no code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (adv && op.kind == hbe_pkg::OP_WRITE) begin
				written_q[op.sym] <= 1'b1;
			end
			if (adv) begin
				valid_s1 <= (op.kind != hbe_pkg::OP_WRITE);
			end else if (rd_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign rd_valid = valid_s1;
	assign rd_kind  = kind_s1;
	assign rd_word  = entry_s1[ENTRY_W-1:LW];
	assign rd_len   = written_s1 ? entry_s1[LW-1:0] : '0;

endmodule

// ===== hdl/hbe_pack.sv =====
// Bit packer: appends code words MSB first, emits one byte per beat, closes a stream on flush.
// Depends on hbe_pkg; driven by hbe_table.

module hbe_pack #(
	parameter int MAX_CODE_LEN = 48,
	parameter int COUNT_BITS   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  hbe_pkg::op_kind_t                 in_kind,
	input  logic [MAX_CODE_LEN-1:0]           in_word,
	input  logic [$clog2(MAX_CODE_LEN+1)-1:0] in_len,
	output logic                              in_ready,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [hbe_pkg::BYTE_W-1:0]        packed_byte,
	output logic                              byte_present,
	output logic                              is_last,
	output logic [hbe_pkg::PAD_W-1:0]         pad_bits,
	output logic [hbe_pkg::OUT_COUNT_W-1:0]   encoded_symbols
);

	localparam int ACC_W = MAX_CODE_LEN + hbe_pkg::BYTE_W - 1;
	localparam int CW    = $clog2(ACC_W + 1);

	// Only the low cnt_q bits of acc_q are meaningful; the oldest is the highest of them.
	logic [ACC_W-1:0]             acc_q;
	logic [CW-1:0]                cnt_q;
	logic [COUNT_BITS-1:0]        sym_cnt_q;

	logic                         out_free;
	logic                         emit;
	logic [CW-1:0]                cnt_e;
	logic                         sym_take;
	logic                         flush_take;
	logic [ACC_W-1:0]             mask;
	logic [ACC_W-1:0]             word_ext;
	logic [hbe_pkg::BYTE_W-1:0]   emit_byte;
	logic [hbe_pkg::BYTE_W-1:0]   last_byte;

	assign out_free   = !out_valid || out_ready;
	assign emit       = (cnt_q >= CW'(hbe_pkg::BYTE_W)) && out_free;
	assign cnt_e      = emit ? cnt_q - CW'(hbe_pkg::BYTE_W) : cnt_q;
	assign in_ready   = (in_kind == hbe_pkg::OP_SYM) ? (cnt_e < CW'(hbe_pkg::BYTE_W))
	                  : ((cnt_q < CW'(hbe_pkg::BYTE_W)) && out_free);
	assign sym_take   = in_valid && in_ready && (in_kind == hbe_pkg::OP_SYM);
	assign flush_take = in_valid && in_ready && (in_kind != hbe_pkg::OP_SYM);

	assign mask      = (ACC_W'(1) << in_len) - ACC_W'(1);
	assign word_ext  = ACC_W'(in_word) & mask;
	assign emit_byte = hbe_pkg::BYTE_W'(acc_q >> (cnt_q - CW'(hbe_pkg::BYTE_W)));
	assign last_byte = hbe_pkg::BYTE_W'(acc_q << (CW'(hbe_pkg::BYTE_W) - cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			sym_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (sym_take) begin
				cnt_q     <= cnt_e + CW'(in_len);
				sym_cnt_q <= sym_cnt_q + COUNT_BITS'(1);
			end else if (flush_take) begin
				cnt_q     <= '0;
				sym_cnt_q <= '0;
			end else begin
				cnt_q <= cnt_e;
			end
			if (emit || flush_take) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sym_take) begin
			acc_q <= (acc_q << in_len) | word_ext;
		end
		if (emit) begin
			packed_byte     <= emit_byte;
			byte_present    <= 1'b1;
			is_last         <= 1'b0;
			pad_bits        <= '0;
			encoded_symbols <= '0;
		end else if (flush_take) begin
			packed_byte     <= last_byte;
			byte_present    <= (cnt_q != '0);
			is_last         <= 1'b1;
			// Eight minus the count, taken modulo eight, is zero for an empty byte.
			pad_bits        <= hbe_pkg::PAD_W'(CW'(hbe_pkg::BYTE_W) - cnt_q);
			encoded_symbols <= hbe_pkg::OUT_COUNT_W'(sym_cnt_q);
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Testbench for huffman_byte_encoder_packer: loads code tables, streams bytes and flushes.
// A built-in encoder model predicts every output beat, and a monitor compares them in order.
// Depends on hbe_pkg and the huffman_byte_encoder_packer RTL only.

module tb_top;

	localparam int CYCLE_LIMIT = 250000;
	localparam int TAIL_CYCLES = 20;
	localparam int LEN_CAP     = 48;
	localparam int RANDOM_CMDS = 305;
	localparam logic [hbe_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

	typedef struct packed {
		logic [hbe_pkg::CMD_W-1:0]     cmd;
		logic [hbe_pkg::SYM_W-1:0]     sym;
		logic [hbe_pkg::IN_WORD_W-1:0] word;
		logic [hbe_pkg::IN_LEN_W-1:0]  len;
		logic [hbe_pkg::BYTE_W-1:0]    data;
		logic                          hold;
	} cmd_item_t;

	typedef struct packed {
		logic [hbe_pkg::BYTE_W-1:0]      octet;
		logic                            present;
		logic                            last;
		logic [hbe_pkg::PAD_W-1:0]       pad;
		logic [hbe_pkg::OUT_COUNT_W-1:0] count;
	} out_beat_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [hbe_pkg::CMD_W-1:0]       s_tuser = '0;
	logic [hbe_pkg::S_TDATA_W-1:0]   s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic                            m_tuser;
	logic [hbe_pkg::M_TDATA_W-1:0]   m_tdata;
	logic                            m_tlast;

	huffman_byte_encoder_packer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	// Encoder model state.
	logic [hbe_pkg::IN_WORD_W-1:0]   code_word [256];
	logic [hbe_pkg::IN_LEN_W-1:0]    code_len [256];
	logic [7:0]                      bit_acc;
	int                              bit_cnt;
	logic                            cr_held;
	logic [hbe_pkg::OUT_COUNT_W-1:0] sym_count;

	out_beat_t  beats_due[$];
	cmd_item_t  cmd_queue[$];
	logic [7:0] known_syms[$];
	logic       hold_next = 1'b0;
	int         mismatches = 0;
	int         cycles = 0;

	cmd_item_t  live_item, next_item;
	logic       feeding = 1'b0;
	logic       send_calm = 1'b0;
	int         send_gap = 0;
	logic       recv_calm = 1'b0;
	int         recv_gap = 0;
	out_beat_t  seen, want;

	function automatic logic [hbe_pkg::IN_WORD_W-1:0] rand_word();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[hbe_pkg::IN_WORD_W-1:0];
	endfunction

	function automatic void emit_beat(logic [7:0] octet, logic present, logic last,
			logic [hbe_pkg::PAD_W-1:0] pad, logic [hbe_pkg::OUT_COUNT_W-1:0] count);
		out_beat_t b;
		b.octet   = octet;
		b.present = present;
		b.last    = last;
		b.pad     = pad;
		b.count   = count;
		beats_due = {beats_due, b};
	endfunction

	// Shift one symbol's code into the accumulator, MSB first, emitting each full byte.
	function automatic void encode_sym(logic [7:0] s);
		for (int i = int'(code_len[s]) - 1; i >= 0; i--) begin
			bit_acc = {bit_acc[6:0], code_word[s][i]};
			bit_cnt++;
			if (bit_cnt == 8) begin
				emit_beat(bit_acc, 1'b1, 1'b0, '0, '0);
				bit_acc = '0;
				bit_cnt = 0;
			end
		end
		sym_count++;
	endfunction

	function automatic void apply_command(cmd_item_t it);
		int pad;
		case (it.cmd)
			hbe_pkg::CMD_LOAD: begin
				code_word[it.sym] = it.word;
				code_len[it.sym]  = (it.len > LEN_CAP) ? hbe_pkg::IN_LEN_W'(LEN_CAP) : it.len;
			end
			hbe_pkg::CMD_ENCODE: begin
				if (cr_held) begin
					if (it.data == hbe_pkg::CH_LF) begin
						cr_held = 1'b0;
						encode_sym(hbe_pkg::CH_LF);
					end else begin
						encode_sym(hbe_pkg::CH_CR);
						if (it.data != hbe_pkg::CH_CR) begin
							cr_held = 1'b0;
							encode_sym(it.data);
						end
					end
				end else if (it.data == hbe_pkg::CH_CR) begin
					cr_held = 1'b1;
				end else begin
					encode_sym(it.data);
				end
			end
			hbe_pkg::CMD_FLUSH: begin
				if (cr_held) begin
					cr_held = 1'b0;
					encode_sym(hbe_pkg::CH_CR);
				end
				if (bit_cnt > 0) begin
					pad = 8 - bit_cnt;
					emit_beat(bit_acc << pad, 1'b1, 1'b1, hbe_pkg::PAD_W'(pad), sym_count);
				end else begin
					emit_beat('0, 1'b0, 1'b1, '0, sym_count);
				end
				bit_acc   = '0;
				bit_cnt   = 0;
				sym_count = '0;
			end
			default: ;
		endcase
	endfunction

	function automatic logic [hbe_pkg::S_TDATA_W-1:0] pack_item(cmd_item_t it);
		logic [hbe_pkg::S_TDATA_W-1:0] v;
		v = '0;
		v[hbe_pkg::SD_SYM_LO +: hbe_pkg::SYM_W]      = it.sym;
		v[hbe_pkg::SD_WORD_LO +: hbe_pkg::IN_WORD_W] = it.word;
		v[hbe_pkg::SD_LEN_LO +: hbe_pkg::IN_LEN_W]   = it.len;
		v[hbe_pkg::SD_DATA_LO +: hbe_pkg::BYTE_W]    = it.data;
		return v;
	endfunction

	// Fields that a command does not use are filled with random values.
	task automatic push_item(logic [hbe_pkg::CMD_W-1:0] cmd, logic [7:0] sym,
			logic [hbe_pkg::IN_WORD_W-1:0] word, logic [hbe_pkg::IN_LEN_W-1:0] len,
			logic [7:0] data);
		cmd_item_t it;
		it.cmd  = cmd;
		it.sym  = sym;
		it.word = word;
		it.len  = len;
		it.data = data;
		it.hold = hold_next;
		hold_next = 1'b0;
		if (cmd != hbe_pkg::CMD_LOAD) begin
			it.sym  = 8'($urandom_range(0, 255));
			it.word = rand_word();
			it.len  = hbe_pkg::IN_LEN_W'($urandom_range(0, 63));
		end else begin
			known_syms = {known_syms, sym};
		end
		if (cmd != hbe_pkg::CMD_ENCODE)
			it.data = 8'($urandom_range(0, 255));
		cmd_queue = {cmd_queue, it};
	endtask

	function automatic logic [hbe_pkg::IN_LEN_W-1:0] rand_len();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return hbe_pkg::IN_LEN_W'($urandom_range(13, 63));
			default: return hbe_pkg::IN_LEN_W'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic logic [7:0] rand_data();
		int k;
		k = $urandom_range(0, 9);
		if (k < 2)
			return hbe_pkg::CH_CR;
		if (k == 2)
			return hbe_pkg::CH_LF;
		return known_syms[$urandom_range(0, known_syms.size() - 1)];
	endfunction

	initial begin
		int n;
		int k;
		for (int i = 0; i < 256; i++)
			code_len[i] = '0;
		bit_acc   = '0;
		bit_cnt   = 0;
		cr_held   = 1'b0;
		sym_count = '0;

		// Directed part: empty flush, table extremes, line-ending folding, ignored command.
		push_item(hbe_pkg::CMD_FLUSH, '0, '0, '0, '0);
		push_item(hbe_pkg::CMD_LOAD, 8'h00, '1, 6'd48, '0);
		push_item(hbe_pkg::CMD_LOAD, 8'hFF, rand_word(), 6'd63, '0);
		push_item(hbe_pkg::CMD_LOAD, hbe_pkg::CH_CR, 48'h5, 6'd3, '0);
		push_item(hbe_pkg::CMD_LOAD, hbe_pkg::CH_LF, 48'h1, 6'd2, '0);
		push_item(hbe_pkg::CMD_LOAD, 8'h20, rand_word(), 6'd0, '0);
		push_item(hbe_pkg::CMD_LOAD, 8'h41, 48'hFFFF_FFFF_FF05, 6'd5, '0);
		push_item(CMD_NONE, '0, '0, '0, '0);
		push_item(hbe_pkg::CMD_ENCODE, '0, '0, '0, 8'h00);
		push_item(hbe_pkg::CMD_ENCODE, '0, '0, '0, 8'h41);
		push_item(hbe_pkg::CMD_ENCODE, '0, '0, '0, hbe_pkg::CH_CR);
		push_item(hbe_pkg::CMD_ENCODE, '0, '0, '0, hbe_pkg::CH_LF);
		push_item(hbe_pkg::CMD_ENCODE, '0, '0, '0, hbe_pkg::CH_CR);
		push_item(hbe_pkg::CMD_ENCODE, '0, '0, '0, 8'h41);
		push_item(hbe_pkg::CMD_ENCODE, '0, '0, '0, hbe_pkg::CH_CR);
		push_item(hbe_pkg::CMD_ENCODE, '0, '0, '0, hbe_pkg::CH_CR);
		push_item(hbe_pkg::CMD_ENCODE, '0, '0, '0, hbe_pkg::CH_LF);
		push_item(hbe_pkg::CMD_ENCODE, '0, '0, '0, 8'h20);
		push_item(hbe_pkg::CMD_ENCODE, '0, '0, '0, hbe_pkg::CH_CR);
		push_item(hbe_pkg::CMD_FLUSH, '0, '0, '0, '0);
		push_item(hbe_pkg::CMD_ENCODE, '0, '0, '0, 8'hFF);
		push_item(hbe_pkg::CMD_ENCODE, '0, '0, '0, 8'h00);
		push_item(hbe_pkg::CMD_FLUSH, '0, '0, '0, '0);

		// Random part: mostly byte streams over loaded symbols, with reloads, flushes and ignored commands.
		hold_next = 1'b1;
		n = 0;
		while (n < RANDOM_CMDS) begin
			k = $urandom_range(0, 99);
			if (k < 12) begin
				push_item(hbe_pkg::CMD_LOAD, 8'($urandom_range(0, 255)), rand_word(),
					rand_len(), '0);
			end else if (k < 16) begin
				push_item(hbe_pkg::CMD_FLUSH, '0, '0, '0, '0);
			end else if (k < 18) begin
				push_item(CMD_NONE, '0, '0, '0, '0);
				n--;
			end else begin
				push_item(hbe_pkg::CMD_ENCODE, '0, '0, '0, rand_data());
			end
			n++;
			if (n == RANDOM_CMDS / 2)
				hold_next = 1'b1;
		end
		push_item(hbe_pkg::CMD_FLUSH, '0, '0, '0, '0);

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (cmd_queue.size() != 0 || feeding || beats_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && beats_due.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// Driver: one command beat at a time, with a random gap after each accepted beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			feeding = 1'b0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_command(live_item);
				feeding = 1'b0;
			end
			if (!feeding) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (cmd_queue.size() != 0) begin
					next_item = cmd_queue[0];
					// A marked beat waits until every predicted output beat has drained.
					if (!(next_item.hold && beats_due.size() != 0)) begin
						live_item = cmd_queue.pop_front();
						feeding = 1'b1;
						if ($urandom_range(0, 39) == 0)
							send_calm = !send_calm;
						send_gap = send_calm ? 0 : $urandom_range(0, 7);
					end
				end
			end
			s_tvalid <= feeding;
			if (feeding) begin
				s_tuser <= live_item.cmd;
				s_tdata <= pack_item(live_item);
			end
		end
	end

	// Monitor: checks each output beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.octet   = m_tdata[hbe_pkg::MD_BYTE_LO +: hbe_pkg::BYTE_W];
				seen.present = m_tuser;
				seen.last    = m_tlast;
				seen.pad     = m_tdata[hbe_pkg::MD_PAD_LO +: hbe_pkg::PAD_W];
				seen.count   = m_tdata[hbe_pkg::MD_CNT_LO +: hbe_pkg::OUT_COUNT_W];
				if (beats_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected beat: got byte %h present %b last %b pad %0d count %0d",
						$time, seen.octet, seen.present, seen.last, seen.pad, seen.count);
				end else begin
					want = beats_due.pop_front();
					if (seen !== want) begin
						mismatches++;
						$display("%0t: mismatch: expected byte %h present %b last %b pad %0d count %0d",
							$time, want.octet, want.present, want.last, want.pad, want.count);
						$display("%0t:           actual byte %h present %b last %b pad %0d count %0d",
							$time, seen.octet, seen.present, seen.last, seen.pad, seen.count);
					end
				end
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
				recv_gap = recv_calm ? 0 : $urandom_range(0, 7);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

endmodule
